@@ src/lbr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lattice basis reduction package
// Constants and control types shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

   // Widths of the scalar, the vector coordinates and the norms.
   localparam int KW = 256;
   localparam int VW = 192;
   localparam int NW = 512;
   localparam int BW = 10;

   // Group order r and its square.
   localparam logic [KW-1:0] R_ORDER = {
      64'h4000000000000000, 64'h0000000000000000,
      64'h2ACF567A912B7F03, 64'hDCF2AC65396152C7};
   localparam logic [NW-1:0] R_SQUARED = {
      64'h1000000000000000, 64'h0000000000000000,
      64'h1567AB3D4895BF81, 64'hEE7956329CB0A963,
      64'h8728B04D2F0F9E3C, 64'h95DCE66BF04303AD,
      64'h86A297C9835B5211, 64'hA31F34E2739216B1};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic reduce;
      logic mul_init;
      logic mul_step;
      logic init;
      logic swap;
      logic bl1;
      logic bl2;
      logic upd1;
      logic upd2;
      logic store;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stop;
   } status_type;

endpackage

`default_nettype wire

@@ src/lbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Lattice basis reduction controller
// Sequences scalar reduction, the bit-serial products and the reduction loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_ctrl
   import lbr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            idle,
   output logic            rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RED, ST_MINIT, ST_MUL, ST_INIT, ST_SWAP, ST_BL1, ST_BL2,
      ST_CHECK, ST_UPD1, ST_UPD2, ST_WAIT, ST_STORE
   } state_type;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic [7:0]  cnt_ff;
   logic [10:0] iter_ff;
   logic        valid_ff;

   // State, commands for the next cycle, counters and the result valid flag.
   always_ff @(posedge clock) begin
      cmd_type cmd_in;
      cmd_in = '0;
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
         cnt_ff   <= '0;
         iter_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && !rsp_stall) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff      <= ST_RED;
                  cmd_in.reduce = 1'b1;
                  cnt_ff        <= '0;
               end
            end
            ST_RED: begin
               if (cnt_ff == 8'd2) begin
                  state_ff        <= ST_MINIT;
                  cmd_in.mul_init = 1'b1;
               end else begin
                  cnt_ff        <= cnt_ff + 8'd1;
                  cmd_in.reduce = 1'b1;
               end
            end
            ST_MINIT: begin
               state_ff        <= ST_MUL;
               cmd_in.mul_step = 1'b1;
               cnt_ff          <= '0;
            end
            ST_MUL: begin
               if (cnt_ff == 8'd255) begin
                  state_ff    <= ST_INIT;
                  cmd_in.init = 1'b1;
               end else begin
                  cnt_ff          <= cnt_ff + 8'd1;
                  cmd_in.mul_step = 1'b1;
               end
            end
            ST_INIT: begin
               state_ff    <= ST_SWAP;
               cmd_in.swap = 1'b1;
               iter_ff     <= '0;
            end
            ST_SWAP: begin
               state_ff   <= ST_BL1;
               cmd_in.bl1 = 1'b1;
            end
            ST_BL1: begin
               state_ff   <= ST_BL2;
               cmd_in.bl2 = 1'b1;
            end
            ST_BL2: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (status.stop) begin
                  state_ff <= ST_WAIT;
               end else begin
                  state_ff    <= ST_UPD1;
                  cmd_in.upd1 = 1'b1;
               end
            end
            ST_UPD1: begin
               state_ff    <= ST_UPD2;
               cmd_in.upd2 = 1'b1;
            end
            ST_UPD2: begin
               // The pass counter bounds the loop as a safety measure.
               if (iter_ff == 11'h7FF) begin
                  state_ff <= ST_WAIT;
               end else begin
                  iter_ff     <= iter_ff + 11'd1;
                  state_ff    <= ST_SWAP;
                  cmd_in.swap = 1'b1;
               end
            end
            ST_WAIT: begin
               if (!valid_ff || !rsp_stall) begin
                  state_ff     <= ST_STORE;
                  cmd_in.store = 1'b1;
               end
            end
            ST_STORE: begin
               state_ff <= ST_IDLE;
               valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         cmd_ff <= cmd_in;
      end
   end

   assign cmd       = cmd_ff;
   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

@@ src/lbr_dpath.sv @@
// ----------------------------------------------------------------------------
// Lattice basis reduction datapath
// Holds the scalar, basis vectors, norms and dot product and their updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_dpath
   import lbr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          load,
   input  wire logic [KW-1:0] k_in,
   input  wire cmd_type       cmd,
   output status_type         status,
   output logic [VW-1:0]      c0_out,
   output logic [VW-1:0]      c1_out
);

   logic [KW-1:0] k_ff, k_in_n, kq_ff, kq_in;
   logic [VW-1:0] u0_ff, u0_in, u1_ff, u1_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [NW-1:0] nu_ff, nu_in, nv_ff, nv_in, sp_ff, sp_in;
   logic [6:0]    wnv_ff [8];
   logic [6:0]    wsp_ff [8];
   logic [6:0]    wnv_in [8];
   logic [6:0]    wsp_in [8];
   logic [BW-1:0] blnv_ff, blnv_in, s_ff, s_in;
   logic [VW-1:0] c0_ff, c1_ff;

   // Bit length of one 64-bit word.
   function automatic logic [6:0] word_bl(input logic [63:0] w);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (w[i]) begin
            n = 7'(i + 1);
         end
      end
      return n;
   endfunction

   // Bit length from the per-word lengths: the highest nonzero word wins.
   function automatic logic [BW-1:0] total_bl(input logic [6:0] w [8]);
      logic [BW-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         if (w[i] != 7'd0) begin
            n = BW'(64 * i) + BW'(w[i]);
         end
      end
      return n;
   endfunction

   logic [NW-1:0] nvx, spx;
   logic [BW-1:0] blsp;
   logic          pos;
   logic [10:0]   sh1, sh2;

   assign nvx  = nv_ff ^ {NW{nv_ff[NW-1]}};
   assign spx  = sp_ff ^ {NW{sp_ff[NW-1]}};
   assign blsp = total_bl(wsp_ff);
   assign pos  = !sp_ff[NW-1];
   assign sh1  = {1'b0, s_ff} + 11'd1;
   assign sh2  = {s_ff, 1'b0};

   // Next-state logic for every command.
   always_comb begin
      k_in_n  = k_ff;
      kq_in   = kq_ff;
      u0_in   = u0_ff;
      u1_in   = u1_ff;
      v0_in   = v0_ff;
      v1_in   = v1_ff;
      nu_in   = nu_ff;
      nv_in   = nv_ff;
      sp_in   = sp_ff;
      blnv_in = blnv_ff;
      s_in    = s_ff;
      for (int i = 0; i < 8; i++) begin
         wnv_in[i] = wnv_ff[i];
         wsp_in[i] = wsp_ff[i];
      end
      if (load) begin
         k_in_n = k_in;
      end
      // Conditional subtraction of the order.
      if (cmd.reduce && (k_ff >= R_ORDER)) begin
         k_in_n = k_ff - R_ORDER;
      end
      if (cmd.mul_init) begin
         kq_in = k_ff;
         nv_in = '0;
         sp_in = '0;
      end
      // One bit of k*k and k*r, most significant bit first.
      if (cmd.mul_step) begin
         kq_in = {kq_ff[KW-2:0], 1'b0};
         nv_in = {nv_ff[NW-2:0], 1'b0} + (kq_ff[KW-1] ? NW'(k_ff) : '0);
         sp_in = {sp_ff[NW-2:0], 1'b0} + (kq_ff[KW-1] ? NW'(R_ORDER) : '0);
      end
      if (cmd.init) begin
         nv_in = nv_ff + NW'(1);
         nu_in = R_SQUARED;
         u0_in = R_ORDER[VW-1:0];
         u1_in = '0;
         v0_in = k_ff[VW-1:0];
         v1_in = VW'(1);
      end
      // Keep the shorter vector in v.
      if (cmd.swap && (nu_ff < nv_ff)) begin
         u0_in = v0_ff;
         v0_in = u0_ff;
         u1_in = v1_ff;
         v1_in = u1_ff;
         nu_in = nv_ff;
         nv_in = nu_ff;
      end
      if (cmd.bl1) begin
         for (int i = 0; i < 8; i++) begin
            wnv_in[i] = word_bl(nvx[64*i +: 64]);
            wsp_in[i] = word_bl(spx[64*i +: 64]);
         end
      end
      if (cmd.bl2) begin
         blnv_in = total_bl(wnv_ff);
         s_in    = (blsp > total_bl(wnv_ff)) ? blsp - total_bl(wnv_ff) : '0;
      end
      // First half of a pass: vectors and the dot-product term of nu.
      if (cmd.upd1) begin
         if (pos) begin
            u0_in = u0_ff - (v0_ff << s_ff);
            u1_in = u1_ff - (v1_ff << s_ff);
            nu_in = nu_ff - (sp_ff << sh1);
         end else begin
            u0_in = u0_ff + (v0_ff << s_ff);
            u1_in = u1_ff + (v1_ff << s_ff);
            nu_in = nu_ff + (sp_ff << sh1);
         end
      end
      // Second half of a pass: norm term of nu and the dot product.
      if (cmd.upd2) begin
         nu_in = nu_ff + (nv_ff << sh2);
         sp_in = pos ? sp_ff - (nv_ff << s_ff) : sp_ff + (nv_ff << s_ff);
      end
   end

   // Working registers and the result register.
   always_ff @(posedge clock) begin
      k_ff    <= k_in_n;
      kq_ff   <= kq_in;
      u0_ff   <= u0_in;
      u1_ff   <= u1_in;
      v0_ff   <= v0_in;
      v1_ff   <= v1_in;
      nu_ff   <= nu_in;
      nv_ff   <= nv_in;
      sp_ff   <= sp_in;
      blnv_ff <= blnv_in;
      s_ff    <= s_in;
      for (int i = 0; i < 8; i++) begin
         wnv_ff[i] <= wnv_in[i];
         wsp_ff[i] <= wsp_in[i];
      end
      if (cmd.store) begin
         c0_ff <= v0_ff;
         c1_ff <= v1_ff;
      end
   end

   assign status.stop = (blnv_ff <= BW'(255));
   assign c0_out      = c0_ff;
   assign c1_out      = c1_ff;

endmodule

`default_nettype wire

@@ src/lattice_basis_reduce_2d_unit.sv @@
// ----------------------------------------------------------------------------
// Two-dimensional lattice basis reduction unit
// Splits a 256-bit scalar into two short signed coefficients.
// ----------------------------------------------------------------------------
// The request channel carries one 256-bit scalar as four 64-bit words; an
// item is taken when req_valid is high and req_stall is low. req_stall is
// high whenever a scalar is being worked on.
// The response channel returns the two 136-bit two's complement coefficients
// as rsp_c0_* and rsp_c1_*; the downstream side holds rsp_stall to keep the
// item waiting, and the result register keeps it stable meanwhile. A new
// scalar is taken while an earlier result still waits.
// Processing: the scalar is reduced modulo the order by conditional
// subtraction, the two bit-serial 256-bit products k*k and k*r are formed,
// then the reduction loop runs its passes of swap, bit lengths, check and
// the update steps. One item at a time is processed.
// Reset clears the controller and the response valid flag; no item survives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lattice_basis_reduce_2d_unit
   import lbr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_k_w0,
   input  wire logic [63:0] req_k_w1,
   input  wire logic [63:0] req_k_w2,
   input  wire logic [63:0] req_k_w3,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_c0_lo,
   output logic [63:0]      rsp_c0_hi,
   output logic [7:0]       rsp_c0_top,
   output logic [63:0]      rsp_c1_lo,
   output logic [63:0]      rsp_c1_hi,
   output logic [7:0]       rsp_c1_top
);

   cmd_type       cmd;
   status_type    status;
   logic          idle;
   logic          accept;
   logic [VW-1:0] c0, c1;

   // Input handshake.
   assign req_stall = !idle;
   assign accept    = req_valid && idle;

   lbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle),
      .rsp_valid (rsp_valid)
   );

   lbr_dpath u_dpath (
      .clock  (clock),
      .load   (accept),
      .k_in   ({req_k_w3, req_k_w2, req_k_w1, req_k_w0}),
      .cmd    (cmd),
      .status (status),
      .c0_out (c0),
      .c1_out (c1)
   );

   // Result fields.
   assign rsp_c0_lo  = c0[63:0];
   assign rsp_c0_hi  = c0[127:64];
   assign rsp_c0_top = c0[135:128];
   assign rsp_c1_lo  = c1[63:0];
   assign rsp_c1_hi  = c1[127:64];
   assign rsp_c1_top = c1[135:128];

endmodule

`default_nettype wire

@@ verif/lattice_basis_reduce_2d_unit_test.sv @@
// ----------------------------------------------------------------------------
// Lattice basis reduction unit testbench
// Drives 256-bit scalars into the unit with random gaps, predicts both
// coefficients with a behavioral Lagrange reduction and compares each
// returned item in order, with random and long response stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lattice_basis_reduce_2d_unit_test;
   import lbr_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int DRAIN_CYCLES = 1500;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int HOLD_CYCLES = 5000;

   typedef struct {
      logic [63:0] c0_lo;
      logic [63:0] c0_hi;
      logic [7:0]  c0_top;
      logic [63:0] c1_lo;
      logic [63:0] c1_hi;
      logic [7:0]  c1_top;
   } coeff_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [63:0] req_k_w0 = '0;
   logic [63:0] req_k_w1 = '0;
   logic [63:0] req_k_w2 = '0;
   logic [63:0] req_k_w3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [63:0] rsp_c0_lo, rsp_c0_hi, rsp_c1_lo, rsp_c1_hi;
   logic [7:0]  rsp_c0_top, rsp_c1_top;

   logic [KW-1:0]  scalar_queue[$];
   coeff_pair_type coeff_queue[$];
   int error_count = 0;
   int mismatch_count = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit send_burst = 0;
   bit recv_burst = 0;
   bit hold_off = 0;
   bit hold_done = 0;
   int hold_left = 0;

   lattice_basis_reduce_2d_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_k_w0(req_k_w0), .req_k_w1(req_k_w1),
      .req_k_w2(req_k_w2), .req_k_w3(req_k_w3),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_c0_lo(rsp_c0_lo), .rsp_c0_hi(rsp_c0_hi), .rsp_c0_top(rsp_c0_top),
      .rsp_c1_lo(rsp_c1_lo), .rsp_c1_hi(rsp_c1_hi), .rsp_c1_top(rsp_c1_top)
   );

   always #5 clock = ~clock;

   // Bit length of a two's complement value; negatives use their complement.
   function automatic int signed_bit_length(input logic [NW-1:0] x);
      logic [NW-1:0] m;
      m = x[NW-1] ? ~x : x;
      for (int i = NW - 1; i >= 0; i--)
         if (m[i]) return i + 1;
      return 0;
   endfunction

   // Reduce the scalar and run the Lagrange loop to its short vector.
   function automatic coeff_pair_type reduce_scalar(input logic [KW-1:0] k_in);
      logic [KW-1:0] k;
      logic [VW-1:0] u0, u1, v0, v1, tv;
      logic [NW-1:0] nu, nv, sp, tn;
      int bl_nv, bl_sp, s;
      bit pos;
      coeff_pair_type res;
      k = k_in;
      for (int i = 0; i < 3; i++)
         if (k >= R_ORDER) k = k - R_ORDER;
      u0 = VW'(R_ORDER);
      u1 = '0;
      v0 = VW'(k);
      v1 = VW'(1);
      nu = R_SQUARED;
      nv = NW'(k) * NW'(k) + NW'(1);
      sp = NW'(k) * NW'(R_ORDER);
      for (int iter = 0; iter < 2048; iter++) begin
         if (nu < nv) begin
            tv = u0; u0 = v0; v0 = tv;
            tv = u1; u1 = v1; v1 = tv;
            tn = nu; nu = nv; nv = tn;
         end
         bl_nv = signed_bit_length(nv);
         if (bl_nv <= 255) break;
         bl_sp = signed_bit_length(sp);
         s = (bl_sp > bl_nv) ? bl_sp - bl_nv : 0;
         pos = !sp[NW-1];
         // Shifted-out bits are dropped at each width.
         if (pos) begin
            u0 = u0 - (v0 << s);
            u1 = u1 - (v1 << s);
         end else begin
            u0 = u0 + (v0 << s);
            u1 = u1 + (v1 << s);
         end
         nu = nu + (nv << (2 * s));
         if (pos) begin
            nu = nu - (sp << (s + 1));
            sp = sp - (nv << s);
         end else begin
            nu = nu + (sp << (s + 1));
            sp = sp + (nv << s);
         end
      end
      res.c0_lo = v0[63:0];
      res.c0_hi = v0[127:64];
      res.c0_top = v0[135:128];
      res.c1_lo = v1[63:0];
      res.c1_hi = v1[127:64];
      res.c1_top = v1[135:128];
      return res;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KW-1:0] rand_scalar();
      logic [KW-1:0] k;
      int pick;
      k = {rand_word(), rand_word(), rand_word(), rand_word()};
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         // Short scalars.
         k = k >> $urandom_range(1, 255);
      end else if (pick < 6) begin
         // Near a multiple of the order, up to the top of the range.
         k = KW'(R_ORDER) * KW'($urandom_range(0, 3))
             + KW'($urandom_range(0, 64)) - KW'(32);
      end
      return k;
   endfunction

   // Input side: presents pending scalars with random gaps.
   always @(posedge clock) begin
      logic next_valid;
      int g;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         next_valid = req_valid;
         g = gap_left;
         if (req_valid && !req_stall) begin
            coeff_queue.push_back(reduce_scalar(scalar_queue.pop_front()));
            next_valid = 1'b0;
            if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
            g = send_burst ? 0 : $urandom_range(0, 4);
         end
         if (!next_valid) begin
            if (g > 0) begin
               g--;
            end else if (scalar_queue.size() > 0) begin
               next_valid = 1'b1;
               {req_k_w3, req_k_w2, req_k_w1, req_k_w0} <= scalar_queue[0];
            end
         end
         req_valid <= next_valid;
         gap_left <= g;
      end
   end

   // Output side: checks each returned item against the oldest prediction.
   always @(posedge clock) begin
      int s;
      coeff_pair_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         s = stall_left;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (coeff_queue.size() == 0) begin
               error_count++;
               $display("Unexpected item on the response channel");
            end else begin
               e = coeff_queue.pop_front();
               if (e.c0_lo !== rsp_c0_lo || e.c0_hi !== rsp_c0_hi ||
                   e.c0_top !== rsp_c0_top || e.c1_lo !== rsp_c1_lo ||
                   e.c1_hi !== rsp_c1_hi || e.c1_top !== rsp_c1_top) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch item %0d: expected c0=%h_%h_%h c1=%h_%h_%h, %s",
                        results_seen, e.c0_top, e.c0_hi, e.c0_lo,
                        e.c1_top, e.c1_hi, e.c1_lo,
                        $sformatf("got c0=%h_%h_%h c1=%h_%h_%h",
                        rsp_c0_top, rsp_c0_hi, rsp_c0_lo,
                        rsp_c1_top, rsp_c1_hi, rsp_c1_lo));
               end
            end
            if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
            s = recv_burst ? 0 : $urandom_range(0, 4);
         end else if (s > 0) begin
            s--;
         end
         rsp_stall <= hold_off || (s > 0);
         stall_left <= s;
      end
   end

   // One long receiver hold-off so that the unit backs up into its input.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && results_seen >= 20) begin
            hold_done <= 1'b1;
            hold_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
         end else if (hold_off) begin
            if (hold_left == 0) hold_off <= 1'b0;
            else hold_left <= hold_left - 1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      // Field extremes, order boundaries and multiples of the order.
      scalar_queue.push_back('0);
      scalar_queue.push_back(KW'(1));
      scalar_queue.push_back(KW'(2));
      scalar_queue.push_back(R_ORDER - KW'(1));
      scalar_queue.push_back(R_ORDER);
      scalar_queue.push_back(R_ORDER + KW'(1));
      scalar_queue.push_back(KW'(R_ORDER) * KW'(2));
      scalar_queue.push_back(KW'(R_ORDER) * KW'(2) - KW'(1));
      scalar_queue.push_back(KW'(R_ORDER) * KW'(3));
      scalar_queue.push_back(KW'(R_ORDER) * KW'(3) + KW'(7));
      scalar_queue.push_back({KW{1'b1}});
      scalar_queue.push_back({1'b1, {(KW-1){1'b0}}});
      scalar_queue.push_back({2'b01, {(KW-2){1'b0}}});
      scalar_queue.push_back({{(KW-64){1'b0}}, {64{1'b1}}});
      scalar_queue.push_back({{64{1'b1}}, {(KW-64){1'b0}}});
      scalar_queue.push_back({4{64'hAAAAAAAAAAAAAAAA}});
      scalar_queue.push_back({4{64'h5555555555555555}});
      scalar_queue.push_back(KW'(R_ORDER >> 1));
      scalar_queue.push_back(KW'(128'h1) << 127);
      scalar_queue.push_back(KW'(R_ORDER) - KW'(64'hFFFFFFFFFFFFFFFF));
      for (int i = 0; i < RANDOM_ITEMS; i++)
         scalar_queue.push_back(rand_scalar());
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Poll the queues once per cycle until every item has come back.
      while (scalar_queue.size() != 0 || req_valid) @(posedge clock);
      while (coeff_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && coeff_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/lbr_pkg.sv
src/lbr_ctrl.sv
src/lbr_dpath.sv
src/lattice_basis_reduce_2d_unit.sv
verif/lattice_basis_reduce_2d_unit_test.sv
